@@ rtl/rdf_pkg.sv @@
// rdf_pkg: shared types and constants for the recent-id duplicate filter.
// No dependencies; used by every rtl file of the block.
package rdf_pkg;

	localparam int HISTORY_DEPTH_DEF = 128;

	localparam logic [3:0] MAX_ATT_RESET = 4'd8;

	// result status codes
	localparam logic [2:0] ST_ACCEPT   = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_GAVE_UP  = 3'd3;
	localparam logic [2:0] ST_SRC_FAIL = 3'd4;

	// register index, taken from paddr[2]
	localparam logic REG_MAX_ATT = 1'b0;

	typedef logic [63:0] half_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FIN
	} state_t;

endpackage

@@ rtl/rdf_cmp.sv @@
// rdf_cmp: shared 128-bit equality unit, used for the zero check and the history scan.
// Depends on rdf_pkg.
module rdf_cmp
	import rdf_pkg::*;
(
	input  half_t a_hi,
	input  half_t a_lo,
	input  half_t b_hi,
	input  half_t b_lo,
	output logic  eq
);

	assign eq = (a_hi == b_hi) && (a_lo == b_lo);

endmodule

@@ rtl/rdf_core.sv @@
// rdf_core: sequencer, history ring memory, counters and output register.
// Depends on rdf_pkg and rdf_cmp.
module rdf_core
	import rdf_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] max_att,
	input  logic       in_valid,
	output logic       in_ready,
	input  half_t      id_high,
	input  half_t      id_low,
	input  logic       source_ok,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output half_t      accepted_high,
	output half_t      accepted_low
);

	localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(HISTORY_DEPTH);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

	state_t state_q, state_d;

	half_t cand_hi_q, cand_lo_q;
	logic  ok_q;
	logic  zero_q, dup_q;
	logic  pend_s1;

	logic [FILL_W-1:0] scan_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [3:0]        attempt_q;

	logic       out_valid_q;
	logic [2:0] status_q;
	half_t      acc_hi_q, acc_lo_q;

	half_t mem_hi [HISTORY_DEPTH];
	half_t mem_lo [HISTORY_DEPTH];
	half_t rd_hi_q, rd_lo_q;

	half_t op_hi, op_lo;
	logic  eq;
	logic  scan_issue;
	logic  fin_go;
	logic  reject;
	logic  give_up;
	logic  store;
	logic  not_full;
	logic [2:0]       fin_status;
	logic [IDX_W-1:0] wr_addr;
	logic [4:0]       att_next;

	rdf_cmp u_cmp (
		.a_hi (cand_hi_q),
		.a_lo (cand_lo_q),
		.b_hi (op_hi),
		.b_lo (op_lo),
		.eq   (eq)
	);

	// control outputs
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		scan_issue = (state_q == S_SCAN) && (scan_q < fill_q);
		fin_go     = (state_q == S_FIN) && (!out_valid_q || out_ready);
		if (state_q == S_CHECK) begin
			op_hi = '0;
			op_lo = '0;
		end else begin
			op_hi = rd_hi_q;
			op_lo = rd_lo_q;
		end
	end

	// result decision
	always_comb begin
		reject   = ok_q && (zero_q || dup_q);
		att_next = {1'b0, attempt_q} + 5'd1;
		give_up  = reject && (att_next >= {1'b0, max_att});
		store    = fin_go && ok_q && !reject;
		not_full = (fill_q < DEPTH_F);
		wr_addr  = not_full ? fill_q[IDX_W-1:0] : oldest_q;
		priority if (!ok_q) begin
			fin_status = ST_SRC_FAIL;
		end else if (!reject) begin
			fin_status = ST_ACCEPT;
		end else if (give_up) begin
			fin_status = ST_GAVE_UP;
		end else if (zero_q) begin
			fin_status = ST_ZERO;
		end else begin
			fin_status = ST_DUP;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!ok_q || eq) state_d = S_FIN;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (!scan_issue && !pend_s1) state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			zero_q      <= 1'b0;
			dup_q       <= 1'b0;
			pend_s1     <= 1'b0;
			scan_q      <= '0;
			fill_q      <= '0;
			oldest_q    <= '0;
			attempt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= scan_issue;
			if (in_valid && in_ready) begin
				scan_q <= '0;
				zero_q <= 1'b0;
				dup_q  <= 1'b0;
			end
			if (state_q == S_CHECK) zero_q <= eq;
			if (scan_issue) scan_q <= scan_q + 1'b1;
			if (pend_s1 && eq) dup_q <= 1'b1;
			if (fin_go) begin
				if (!ok_q || !reject || give_up) attempt_q <= '0;
				else attempt_q <= att_next[3:0];
			end
			if (store) begin
				if (not_full) fill_q <= fill_q + 1'b1;
				else oldest_q <= (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
			end
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cand_hi_q <= id_high;
			cand_lo_q <= id_low;
			ok_q      <= source_ok;
		end
		if (fin_go) begin
			status_q <= fin_status;
			acc_hi_q <= (ok_q && !reject) ? cand_hi_q : '0;
			acc_lo_q <= (ok_q && !reject) ? cand_lo_q : '0;
		end
	end

	// history ring
	always_ff @(posedge clk) begin
		if (store) begin
			mem_hi[wr_addr] <= cand_hi_q;
			mem_lo[wr_addr] <= cand_lo_q;
		end
		if (scan_issue) begin
			rd_hi_q <= mem_hi[scan_q[IDX_W-1:0]];
			rd_lo_q <= mem_lo[scan_q[IDX_W-1:0]];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign accepted_high = acc_hi_q;
	assign accepted_low  = acc_lo_q;

endmodule

@@ rtl/recent_id_duplicate_filter_top.sv @@
// recent_id_duplicate_filter_top: APB register and the filter core.
// Depends on rdf_pkg and rdf_core.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid / in_ready        | id_high, id_low, source_ok
//  out      | out_valid / out_ready      | status, accepted_high, accepted_low
//  cfg      | psel, penable, pwrite      | paddr, pwdata, prdata (pready high)
//
// After the input accept the sequencer checks the candidate for all zeros, then
// scans the history, then registers the result; a source failure or an all-zero
// candidate skips the scan. The scan reads one history entry per cycle through the
// single memory read port. in_ready is high only while the sequencer is idle;
// a result waiting on out_ready holds the sequencer in its final step. Reset
// clears the counters; history memory is not cleared and is tracked by the fill count.
module recent_id_duplicate_filter_top
	import rdf_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  half_t       id_high,
	input  half_t       id_low,
	input  logic        source_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output half_t       accepted_high,
	output half_t       accepted_low
);

	logic [3:0] max_att_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= MAX_ATT_RESET;
		end else if (cfg_wr && (paddr[2] == REG_MAX_ATT)) begin
			max_att_q <= pwdata[3:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_MAX_ATT) prdata = {28'd0, max_att_q};
		else prdata = '0;
	end

	rdf_core #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_att       (max_att_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.id_high       (id_high),
		.id_low        (id_low),
		.source_ok     (source_ok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.accepted_high (accepted_high),
		.accepted_low  (accepted_low)
	);

endmodule

@@ rtl/rdf_checker.sv @@
// rdf_checker: port-level assertions for the duplicate filter, bound to the top level.
// Depends on rdf_pkg and recent_id_duplicate_filter_top.
module rdf_checker
	import rdf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input half_t      accepted_high,
	input half_t      accepted_low
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(accepted_high) && $stable(accepted_low))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_SRC_FAIL)
		else $error("status code out of range");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ACCEPT |-> accepted_high == '0 && accepted_low == '0)
		else $error("identifier shown on a non-accept result");

	a_accept_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ACCEPT |-> (accepted_high | accepted_low) != '0)
		else $error("all-zero identifier accepted");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while one is in work");

endmodule

bind recent_id_duplicate_filter_top rdf_checker u_rdf_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for recent_id_duplicate_filter_top.
// Runs a directed table and then random requests through valid/ready, and writes
// the limit register over APB. Uses rdf_pkg and the block's top level only.
module tb;
	import rdf_pkg::*;

	localparam int HIST = HISTORY_DEPTH_DEF;
	localparam int CLOCK_LIMIT = 600000;
	localparam int HOLD_OFF = 600;
	localparam int HOLD_AFTER = 250;
	localparam half_t ZERO = '0;
	localparam half_t ONES = '1;
	localparam half_t ONE = 64'd1;
	localparam half_t MSB = 64'h8000_0000_0000_0000;
	localparam logic [2:0] ADDR_MAX_ATT = {REG_MAX_ATT, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

	typedef enum {ROW_WRITE, ROW_PREDICT, ROW_FIXED} row_kind_t;

	typedef struct {
		logic [2:0] st;
		half_t      hi;
		half_t      lo;
	} verdict_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  addr;
		logic [31:0] wdata;
		half_t       hi;
		half_t       lo;
		logic        ok;
		verdict_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	half_t       id_high = '0;
	half_t       id_low = '0;
	logic        source_ok = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	half_t       accepted_high;
	half_t       accepted_low;

	// own copy of the filter state
	half_t       hist_hi [HIST];
	half_t       hist_lo [HIST];
	int unsigned fill_cnt = 0;
	int unsigned ring_slot = 0;
	int unsigned reject_cnt = 0;
	logic [3:0]  attempt_limit = MAX_ATT_RESET;

	verdict_t     awaited_verdicts [$];
	logic [127:0] issued_ids [$];
	row_t         plan [$];
	bit           calm = 1'b0;
	int unsigned  errors = 0;
	int unsigned  items_sent = 0;
	int unsigned  checked_results = 0;
	int unsigned  cycles = 0;
	int unsigned  tally [5] = '{0, 0, 0, 0, 0};

	recent_id_duplicate_filter_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.id_high(id_high),
		.id_low(id_low),
		.source_ok(source_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.accepted_high(accepted_high),
		.accepted_low(accepted_low)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CLOCK_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic verdict_t screen_candidate(half_t hi, half_t lo, logic ok);
		verdict_t v;
		bit seen;
		v.st = ST_ACCEPT;
		v.hi = '0;
		v.lo = '0;
		seen = 1'b0;
		if (!ok) begin
			reject_cnt = 0;
			v.st = ST_SRC_FAIL;
		end else begin
			if (hi == '0 && lo == '0) begin
				v.st = ST_ZERO;
			end else begin
				for (int i = 0; i < fill_cnt; i++)
					if (hist_hi[i] == hi && hist_lo[i] == lo)
						seen = 1'b1;
				v.st = seen ? ST_DUP : ST_ACCEPT;
			end
			if (v.st == ST_ACCEPT) begin
				if (fill_cnt < HIST) begin
					hist_hi[fill_cnt] = hi;
					hist_lo[fill_cnt] = lo;
					fill_cnt++;
				end else begin
					hist_hi[ring_slot] = hi;
					hist_lo[ring_slot] = lo;
					ring_slot = (ring_slot + 1 == HIST) ? 0 : ring_slot + 1;
				end
				reject_cnt = 0;
				v.hi = hi;
				v.lo = lo;
			end else if (reject_cnt + 1 >= attempt_limit) begin
				reject_cnt = 0;
				v.st = ST_GAVE_UP;
			end else begin
				reject_cnt = (reject_cnt + 1) & 15;
			end
		end
		return v;
	endfunction

	function automatic row_t row_free(half_t hi, half_t lo, logic ok);
		row_t r;
		r.kind = ROW_PREDICT;
		r.addr = '0;
		r.wdata = '0;
		r.hi = hi;
		r.lo = lo;
		r.ok = ok;
		r.want.st = ST_ACCEPT;
		r.want.hi = '0;
		r.want.lo = '0;
		return r;
	endfunction

	function automatic row_t row_fixed(half_t hi, half_t lo, logic ok, logic [2:0] st,
		half_t ahi, half_t alo);
		row_t r;
		r = row_free(hi, lo, ok);
		r.kind = ROW_FIXED;
		r.want.st = st;
		r.want.hi = ahi;
		r.want.lo = alo;
		return r;
	endfunction

	function automatic row_t row_write(logic [2:0] addr, logic [31:0] wdata);
		row_t r;
		r = row_free(ZERO, ZERO, 1'b0);
		r.kind = ROW_WRITE;
		r.addr = addr;
		r.wdata = wdata;
		return r;
	endfunction

	task automatic offer(half_t hi, half_t lo, logic ok, bit use_want, verdict_t want);
		int unsigned gap;
		verdict_t got;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		id_high <= hi;
		id_low <= lo;
		source_ok <= ok;
		do @(posedge clk); while (!in_ready);
		got = screen_candidate(hi, lo, ok);
		if (got.st == ST_ACCEPT)
			issued_ids.push_back({hi, lo});
		awaited_verdicts.push_back(use_want ? want : got);
		items_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (awaited_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] wdata);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr[2] == REG_MAX_ATT)
			attempt_limit = wdata[3:0];
	endtask

	function automatic half_t rand_half;
		return {$urandom, $urandom};
	endfunction

	task automatic run_requests(int unsigned quota);
		int unsigned n;
		int unsigned k;
		int unsigned lim;
		int unsigned depth;
		half_t hi;
		half_t lo;
		logic [127:0] pick;
		verdict_t none;
		none.st = ST_ACCEPT;
		none.hi = '0;
		none.lo = '0;
		n = 0;
		while (n < quota) begin
			lim = (attempt_limit == 0) ? 1 : attempt_limit;
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim + 1) : $urandom_range(0, 1);
			repeat (k) begin
				case ($urandom_range(0, 9))
					0: offer(rand_half(), rand_half(), 1'b0, 1'b0, none);
					1, 2, 3: offer(ZERO, ZERO, 1'b1, 1'b0, none);
					default: begin
						if (issued_ids.size() == 0) begin
							offer(ZERO, ZERO, 1'b1, 1'b0, none);
						end else begin
							depth = (issued_ids.size() < 200) ? issued_ids.size() : 200;
							pick = issued_ids[issued_ids.size() - 1 - $urandom_range(0, depth - 1)];
							offer(pick[127:64], pick[63:0], 1'b1, 1'b0, none);
						end
					end
				endcase
				n++;
			end
			case ($urandom_range(0, 19))
				0: begin
					hi = $urandom_range(0, 1) ? rand_half() : ZERO;
					offer(hi, hi ^ rand_half(), 1'b0, 1'b0, none);
					n++;
				end
				1: ;
				default: begin
					hi = rand_half();
					lo = rand_half();
					case ($urandom_range(0, 9))
						0: hi = ZERO;
						1: lo = ZERO;
						2: hi = ONES;
						default: ;
					endcase
					offer(hi, lo, 1'b1, 1'b0, none);
					n++;
				end
			endcase
		end
	endtask

	// stimulus
	initial begin
		logic [31:0] limits [6];
		limits = '{32'h0000_0008, 32'h0000_0001, 32'h0000_000F, 32'hFFFF_FFF0,
			32'h0000_0004, 32'hA5A5_A5A2};

		// reset state, limit 8
		plan.push_back(row_fixed(ONES, ONES, 1'b1, ST_ACCEPT, ONES, ONES));
		plan.push_back(row_fixed(ZERO, ZERO, 1'b0, ST_SRC_FAIL, ZERO, ZERO));
		plan.push_back(row_fixed(ZERO, ZERO, 1'b1, ST_ZERO, ZERO, ZERO));
		plan.push_back(row_fixed(ONES, ONES, 1'b1, ST_DUP, ZERO, ZERO));
		plan.push_back(row_fixed(ZERO, ONE, 1'b1, ST_ACCEPT, ZERO, ONE));
		plan.push_back(row_fixed(MSB, ZERO, 1'b1, ST_ACCEPT, MSB, ZERO));
		plan.push_back(row_fixed(ZERO, ONE, 1'b1, ST_DUP, ZERO, ZERO));
		plan.push_back(row_fixed(ONES, ONES, 1'b0, ST_SRC_FAIL, ZERO, ZERO));
		plan.push_back(row_free(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1));
		plan.push_back(row_write(ADDR_MAX_ATT, 32'd2));
		plan.push_back(row_fixed(ZERO, ZERO, 1'b1, ST_ZERO, ZERO, ZERO));
		plan.push_back(row_fixed(MSB, ZERO, 1'b1, ST_GAVE_UP, ZERO, ZERO));
		// limit zero acts as one
		plan.push_back(row_write(ADDR_MAX_ATT, 32'd0));
		plan.push_back(row_fixed(ZERO, ZERO, 1'b1, ST_GAVE_UP, ZERO, ZERO));
		plan.push_back(row_write(ADDR_MAX_ATT, 32'hFFFF_FFFF));
		plan.push_back(row_free(ZERO, ZERO, 1'b1));
		plan.push_back(row_free(ONES, ONES, 1'b1));
		plan.push_back(row_free(ZERO, ZERO, 1'b1));
		// limit dropped under the running count
		plan.push_back(row_write(ADDR_MAX_ATT, 32'd2));
		plan.push_back(row_fixed(ONES, ONES, 1'b1, ST_GAVE_UP, ZERO, ZERO));
		plan.push_back(row_write(ADDR_UNMAPPED, 32'd1));
		plan.push_back(row_fixed(ZERO, ZERO, 1'b1, ST_ZERO, ZERO, ZERO));
		plan.push_back(row_fixed(ZERO, ONE, 1'b1, ST_GAVE_UP, ZERO, ZERO));
		plan.push_back(row_write(ADDR_MAX_ATT, 32'd8));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_WRITE: apb_write(plan[i].addr, plan[i].wdata);
				ROW_PREDICT: offer(plan[i].hi, plan[i].lo, plan[i].ok, 1'b0, plan[i].want);
				ROW_FIXED: offer(plan[i].hi, plan[i].lo, plan[i].ok, 1'b1, plan[i].want);
				default: ;
			endcase
		end

		for (int p = 0; p < 6; p++) begin
			apb_write(ADDR_MAX_ATT, limits[p]);
			calm = (p == 1);
			run_requests(88);
		end
		calm = 1'b0;

		drain();
		repeat (HIST + 8) @(posedge clk);

		$display("%0d items, %0d results: %0d accepted, %0d zero, %0d duplicate, %0d gave up, %0d source fail",
			items_sent, checked_results, tally[ST_ACCEPT], tally[ST_ZERO], tally[ST_DUP],
			tally[ST_GAVE_UP], tally[ST_SRC_FAIL]);
		$display("history %0d/%0d entries, ring slot %0d, limits 0 to 15 exercised",
			fill_cnt, HIST, ring_slot);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// result side
	initial begin
		int unsigned stall;
		bit held;
		verdict_t want;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 11);
			if (!held && checked_results >= HOLD_AFTER) begin
				held = 1'b1;
				stall = HOLD_OFF;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			checked_results++;
			if (status <= ST_SRC_FAIL)
				tally[status]++;
			if (awaited_verdicts.size() == 0) begin
				$error("result with no item outstanding: status %0d", status);
				errors++;
			end else begin
				want = awaited_verdicts.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
				if (accepted_high !== want.hi) begin
					$error("accepted_high: expected %h, got %h", want.hi, accepted_high);
					errors++;
				end
				if (accepted_low !== want.lo) begin
					$error("accepted_low: expected %h, got %h", want.lo, accepted_low);
					errors++;
				end
			end
		end
	end

endmodule
